/* hw/rtl/triangle_from_planes_cramer_assert.svh */
// Assertion macros for the triangle corner solver
`ifndef TRIANGLE_FROM_PLANES_CRAMER_ASSERT_SVH
`define TRIANGLE_FROM_PLANES_CRAMER_ASSERT_SVH
`ifndef ASSERT_OFF
`define TFPC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("tfpc assertion failed");
`define TFPC_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("tfpc forbidden condition");
`else
`define TFPC_ASSERT(lbl, clk, rst, prop)
`define TFPC_NEVER(lbl, clk, rst, expr)
`endif
`endif

/* hw/rtl/tfpc_pkg.sv */
// Shared types, constants and helpers for the triangle corner solver
`default_nettype none
package tfpc_pkg;
   localparam int FRAC_BITS_DEF = 16;
   localparam int DATA_W        = 32;
   localparam int LIMIT_W       = 48;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 48'd281474977;
   localparam int NLANE         = 9;
   localparam int Q_W           = 33;   // quotient bits kept below the overflow check
   localparam int MAG_W         = 100;  // determinant / numerator width
   localparam int COF_W         = 65;
   localparam int FRONT_STAGES  = 7;
   localparam int DIV_STAGES    = Q_W + 1;
   localparam int PIPE_STAGES   = FRONT_STAGES + DIV_STAGES + 1;

   typedef struct packed {
      logic signed [DATA_W-1:0] plane_nx;
      logic signed [DATA_W-1:0] plane_ny;
      logic signed [DATA_W-1:0] plane_nz;
      logic signed [DATA_W-1:0] plane_dist;
      logic signed [DATA_W-1:0] s_x;
      logic signed [DATA_W-1:0] s_y;
      logic signed [DATA_W-1:0] s_z;
      logic signed [DATA_W-1:0] s_offset;
      logic signed [DATA_W-1:0] t_x;
      logic signed [DATA_W-1:0] t_y;
      logic signed [DATA_W-1:0] t_z;
      logic signed [DATA_W-1:0] t_offset;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] a_x;
      logic signed [DATA_W-1:0] a_y;
      logic signed [DATA_W-1:0] a_z;
      logic signed [DATA_W-1:0] b_x;
      logic signed [DATA_W-1:0] b_y;
      logic signed [DATA_W-1:0] b_z;
      logic signed [DATA_W-1:0] c_x;
      logic signed [DATA_W-1:0] c_y;
      logic signed [DATA_W-1:0] c_z;
      logic                     singular;
   } rsp_type;

   // status of one lane leaving the divider
   typedef struct packed {
      logic ov;
      logic neg;
   } lane_flags_type;

   function automatic int next3(input int i);
      return (i == 2) ? 0 : i + 1;
   endfunction

   // signed saturation of a magnitude quotient to the 32-bit range
   function automatic logic [DATA_W-1:0] sat_q(input logic [Q_W-1:0] q,
                                               input lane_flags_type fl);
      logic [Q_W-1:0] qn;
      logic [Q_W-1:0] min_mag;
      qn      = Q_W'(0) - q;
      min_mag = Q_W'(1) << (DATA_W - 1);
      if (fl.neg) begin
         if (fl.ov || q > min_mag) return {1'b1, {(DATA_W-1){1'b0}}};
         return qn[DATA_W-1:0];
      end
      if (fl.ov || q >= min_mag) return {1'b0, {(DATA_W-1){1'b1}}};
      return q[DATA_W-1:0];
   endfunction
endpackage
`default_nettype wire

/* hw/rtl/tfpc_front.sv */
// Cofactor, determinant and numerator stages of the solver
`default_nettype none
module tfpc_front
   import tfpc_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic                             clock,
   input  wire logic [FRONT_STAGES-1:0]          en,
   input  wire req_type                          req_data,
   input  wire logic [LIMIT_W-1:0]               limit,
   output logic      [MAG_W+FRAC_BITS-1:0]       n_out [NLANE],
   output logic      [MAG_W-1:0]                 d_out,
   output logic      [NLANE-1:0]                 neg_out,
   output logic                                  singular_out
);
   localparam int N_W = MAG_W + FRAC_BITS;

   logic signed [DATA_W-1:0] a_in [3][3];
   logic signed [DATA_W-1:0] rhs_in [3];

   // stage 0: cofactor products
   logic signed [2*DATA_W-1:0] pa_ff [3][3], pb_ff [3][3];
   logic signed [DATA_W-1:0]   row0_f0_ff [3], rhs_f0_ff [3];
   // stage 1: cofactors
   logic signed [COF_W-1:0]    cof_ff [3][3];
   logic signed [DATA_W-1:0]   row0_f1_ff [3], rhs_f1_ff [3];
   // stage 2: split partial products
   logic signed [COF_W-1:0]    dlo_ff [3], dhi_ff [3];
   logic signed [COF_W-1:0]    nlo_ff [3][3], nhi_ff [3][3];
   logic signed [COF_W-1:0]    crow_f2_ff [2][3];
   // stage 3: full products
   logic signed [MAG_W-1:0]    detp_ff [3], nump_ff [3][3];
   logic signed [COF_W-1:0]    crow_f3_ff [2][3];
   // stage 4: sums
   logic signed [MAG_W-1:0]    det_ff, base_ff [3];
   logic signed [COF_W-1:0]    crow_f4_ff [2][3];
   // stage 5: numerators for the three right-hand sides
   logic signed [MAG_W-1:0]    num_ff [3][3];
   logic        [MAG_W-1:0]    detmag_ff;
   logic                       det_neg_ff;
   // stage 6: magnitudes ready for division
   logic [N_W-1:0]             n_ff [NLANE];
   logic [MAG_W-1:0]           d_ff;
   logic [NLANE-1:0]           neg_ff;
   logic                       singular_ff;

   always_comb begin
      a_in[0][0] = req_data.plane_nx;  a_in[0][1] = req_data.plane_ny;
      a_in[0][2] = req_data.plane_nz;  a_in[1][0] = req_data.s_x;
      a_in[1][1] = req_data.s_y;       a_in[1][2] = req_data.s_z;
      a_in[2][0] = req_data.t_x;       a_in[2][1] = req_data.t_y;
      a_in[2][2] = req_data.t_z;
      rhs_in[0]  = req_data.plane_dist;
      rhs_in[1]  = req_data.s_offset;
      rhs_in[2]  = req_data.t_offset;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               pa_ff[r][c] <= a_in[next3(r)][next3(c)] * a_in[next3(next3(r))][next3(next3(c))];
               pb_ff[r][c] <= a_in[next3(r)][next3(next3(c))] * a_in[next3(next3(r))][next3(c)];
            end
            row0_f0_ff[r] <= a_in[0][r];
            rhs_f0_ff[r]  <= rhs_in[r];
         end
      end
      if (en[1]) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++)
               cof_ff[r][c] <= COF_W'(pa_ff[r][c]) - COF_W'(pb_ff[r][c]);
            row0_f1_ff[r] <= row0_f0_ff[r];
            rhs_f1_ff[r]  <= rhs_f0_ff[r];
         end
      end
      if (en[2]) begin
         for (int c = 0; c < 3; c++) begin
            dlo_ff[c] <= row0_f1_ff[c] * $signed({1'b0, cof_ff[0][c][31:0]});
            dhi_ff[c] <= row0_f1_ff[c] * $signed(cof_ff[0][c][COF_W-1:32]);
            for (int r = 0; r < 3; r++) begin
               nlo_ff[r][c] <= rhs_f1_ff[r] * $signed({1'b0, cof_ff[r][c][31:0]});
               nhi_ff[r][c] <= rhs_f1_ff[r] * $signed(cof_ff[r][c][COF_W-1:32]);
            end
            crow_f2_ff[0][c] <= cof_ff[1][c];
            crow_f2_ff[1][c] <= cof_ff[2][c];
         end
      end
      if (en[3]) begin
         for (int c = 0; c < 3; c++) begin
            detp_ff[c] <= (MAG_W'(dhi_ff[c]) <<< 32) + MAG_W'(dlo_ff[c]);
            for (int r = 0; r < 3; r++)
               nump_ff[r][c] <= (MAG_W'(nhi_ff[r][c]) <<< 32) + MAG_W'(nlo_ff[r][c]);
            crow_f3_ff[0][c] <= crow_f2_ff[0][c];
            crow_f3_ff[1][c] <= crow_f2_ff[1][c];
         end
      end
      if (en[4]) begin
         det_ff <= detp_ff[0] + detp_ff[1] + detp_ff[2];
         for (int c = 0; c < 3; c++) begin
            base_ff[c]       <= nump_ff[0][c] + nump_ff[1][c] + nump_ff[2][c];
            crow_f4_ff[0][c] <= crow_f3_ff[0][c];
            crow_f4_ff[1][c] <= crow_f3_ff[1][c];
         end
      end
      if (en[5]) begin
         // raising an offset by one adds that row's cofactor scaled by one
         for (int c = 0; c < 3; c++) begin
            num_ff[0][c] <= base_ff[c];
            num_ff[1][c] <= base_ff[c] + (MAG_W'(crow_f4_ff[0][c]) <<< FRAC_BITS);
            num_ff[2][c] <= base_ff[c] + (MAG_W'(crow_f4_ff[1][c]) <<< FRAC_BITS);
         end
         detmag_ff  <= det_ff[MAG_W-1] ? MAG_W'(-det_ff) : MAG_W'(det_ff);
         det_neg_ff <= det_ff[MAG_W-1];
      end
      if (en[6]) begin
         for (int k = 0; k < 3; k++) begin
            for (int c = 0; c < 3; c++) begin
               n_ff[k*3+c] <= N_W'(num_ff[k][c][MAG_W-1] ? MAG_W'(-num_ff[k][c])
                                                       : MAG_W'(num_ff[k][c])) << FRAC_BITS;
               neg_ff[k*3+c] <= num_ff[k][c][MAG_W-1] ^ det_neg_ff;
            end
         end
         d_ff        <= detmag_ff;
         singular_ff <= (detmag_ff == '0) || (detmag_ff < MAG_W'(limit));
      end
   end

   assign n_out        = n_ff;
   assign d_out        = d_ff;
   assign neg_out      = neg_ff;
   assign singular_out = singular_ff;
endmodule
`default_nettype wire

/* hw/rtl/tfpc_div.sv */
// Nine-lane restoring divider: an overflow check stage, then one quotient bit per stage
`default_nettype none
module tfpc_div
   import tfpc_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic                        clock,
   input  wire logic [DIV_STAGES-1:0]       en,
   input  wire logic [MAG_W+FRAC_BITS-1:0]  n_in [NLANE],
   input  wire logic [MAG_W-1:0]            d_in,
   input  wire logic [NLANE-1:0]            neg_in,
   input  wire logic                        singular_in,
   output logic      [Q_W-1:0]              q_out [NLANE],
   output lane_flags_type                   flags_out [NLANE],
   output logic                             singular_out
);
   localparam int N_W = MAG_W + FRAC_BITS;
   localparam int CW  = N_W + Q_W;

   logic [N_W-1:0]   rem_ff [DIV_STAGES][NLANE];
   logic [N_W-1:0]   rem_in [DIV_STAGES][NLANE];
   logic [Q_W-1:0]   q_ff   [DIV_STAGES][NLANE];
   logic [Q_W-1:0]   q_in   [DIV_STAGES][NLANE];
   logic             ov_ff  [DIV_STAGES][NLANE];
   logic             ov_in  [DIV_STAGES][NLANE];
   logic [NLANE-1:0] neg_ff [DIV_STAGES];
   logic [MAG_W-1:0] d_ff   [DIV_STAGES];
   logic             sing_ff [DIV_STAGES];

   always_comb begin
      logic [CW-1:0] dsh;
      logic          ge;
      dsh = '0;
      ge  = 1'b0;
      for (int l = 0; l < NLANE; l++) begin
         // first stage only flags quotients of 2^Q_W or more
         rem_in[0][l] = n_in[l];
         q_in[0][l]   = '0;
         ov_in[0][l]  = CW'(n_in[l]) >= (CW'(d_in) << Q_W);
      end
      for (int j = 1; j < DIV_STAGES; j++) begin
         for (int l = 0; l < NLANE; l++) begin
            dsh          = CW'(d_ff[j-1]) << (Q_W - j);
            ge           = CW'(rem_ff[j-1][l]) >= dsh;
            rem_in[j][l] = ge ? rem_ff[j-1][l] - dsh[N_W-1:0] : rem_ff[j-1][l];
            q_in[j][l]   = q_ff[j-1][l] | (Q_W'(ge) << (Q_W - j));
            ov_in[j][l]  = ov_ff[j-1][l];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < DIV_STAGES; j++) begin
         if (en[j]) begin
            for (int l = 0; l < NLANE; l++) begin
               rem_ff[j][l] <= rem_in[j][l];
               q_ff[j][l]   <= q_in[j][l];
               ov_ff[j][l]  <= ov_in[j][l];
            end
            if (j == 0) begin
               neg_ff[j]  <= neg_in;
               d_ff[j]    <= d_in;
               sing_ff[j] <= singular_in;
            end else begin
               neg_ff[j]  <= neg_ff[j-1];
               d_ff[j]    <= d_ff[j-1];
               sing_ff[j] <= sing_ff[j-1];
            end
         end
      end
   end

   always_comb begin
      for (int l = 0; l < NLANE; l++) begin
         q_out[l]         = q_ff[DIV_STAGES-1][l];
         flags_out[l].ov  = ov_ff[DIV_STAGES-1][l];
         flags_out[l].neg = neg_ff[DIV_STAGES-1][l];
      end
   end
   assign singular_out = sing_ff[DIV_STAGES-1];
endmodule
`default_nettype wire

/* hw/rtl/triangle_from_planes_cramer.sv */
// Top level: triangle corners from three planes by Cramer's rule
//
//   port group   dir   handshake               payload
//   req_*        in    req_valid / req_ready   req_data  (req_type)
//   rsp_*        out   rsp_valid / rsp_ready   rsp_data  (rsp_type)
//   csr_*        in    csr_wr_en               csr_wr_data (singular limit)
//
// One transfer per cycle in each direction while rsp_ready is not held low; the pipeline has
// PIPE_STAGES stages: 7 arithmetic stages, 34 divider stages (overflow check plus 33 quotient bits)
// and the output register.
// Reset clears the stage valid bits and loads the default singular limit.
// Each full stage holds while the next one cannot load; empty stages keep filling, so
// a stalled output still lets new transfers in until the pipe is full.
`default_nettype none
`include "triangle_from_planes_cramer_assert.svh"
module triangle_from_planes_cramer
   import tfpc_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire req_type            req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output rsp_type                 rsp_data,
   input  wire logic               csr_wr_en,
   input  wire logic [LIMIT_W-1:0] csr_wr_data
);
   localparam int N_W = MAG_W + FRAC_BITS;

   logic [LIMIT_W-1:0]     limit_ff;
   logic [PIPE_STAGES-1:0] v_ff, v_in, en;

   logic [N_W-1:0]     fd_n [NLANE];
   logic [MAG_W-1:0]   fd_d;
   logic [NLANE-1:0]   fd_neg;
   logic               fd_singular;
   logic [Q_W-1:0]     dv_q [NLANE];
   lane_flags_type     dv_flags [NLANE];
   logic               dv_singular;
   logic [DATA_W-1:0]  corner [NLANE];
   rsp_type            rsp_ff, rsp_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   // a stage may load when it is empty or its content moves on
   always_comb begin
      en[PIPE_STAGES-1] = !v_ff[PIPE_STAGES-1] || rsp_ready;
      for (int i = PIPE_STAGES - 2; i >= 0; i--)
         en[i] = !v_ff[i] || en[i+1];
      for (int i = 0; i < PIPE_STAGES; i++) begin
         if (en[i]) v_in[i] = (i == 0) ? req_valid : v_ff[i-1];
         else       v_in[i] = v_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_ready = en[0];

   tfpc_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock        (clock),
      .en           (en[FRONT_STAGES-1:0]),
      .req_data     (req_data),
      .limit        (limit_ff),
      .n_out        (fd_n),
      .d_out        (fd_d),
      .neg_out      (fd_neg),
      .singular_out (fd_singular)
   );

   tfpc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock        (clock),
      .en           (en[FRONT_STAGES+DIV_STAGES-1:FRONT_STAGES]),
      .n_in         (fd_n),
      .d_in         (fd_d),
      .neg_in       (fd_neg),
      .singular_in  (fd_singular),
      .q_out        (dv_q),
      .flags_out    (dv_flags),
      .singular_out (dv_singular)
   );

   always_comb begin
      for (int l = 0; l < NLANE; l++)
         corner[l] = dv_singular ? '0 : sat_q(dv_q[l], dv_flags[l]);
      rsp_in.a_x      = corner[0];
      rsp_in.a_y      = corner[1];
      rsp_in.a_z      = corner[2];
      rsp_in.b_x      = corner[3];
      rsp_in.b_y      = corner[4];
      rsp_in.b_z      = corner[5];
      rsp_in.c_x      = corner[6];
      rsp_in.c_y      = corner[7];
      rsp_in.c_z      = corner[8];
      rsp_in.singular = dv_singular;
   end

   always_ff @(posedge clock) begin
      if (en[PIPE_STAGES-1]) rsp_ff <= rsp_in;
   end

   assign rsp_valid = v_ff[PIPE_STAGES-1];
   assign rsp_data  = rsp_ff;

   `TFPC_ASSERT(a_full_when_blocked, clock, reset, !req_ready |-> (&v_ff))
   `TFPC_ASSERT(a_accept_enters, clock, reset, (req_valid && req_ready) |=> v_ff[0])
   `TFPC_NEVER(a_singular_zero, clock, reset, rsp_valid && rsp_data.singular && (rsp_data.a_x != '0 || rsp_data.b_y != '0 || rsp_data.c_z != '0))
endmodule
`default_nettype wire

/* dv/tfpc_checker.sv */
// Checker for the triangle corner solver: predicts corners and compares results
`timescale 1ns / 100ps
module tfpc_checker
   import tfpc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_ready,
   input  wire req_type            req_data,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_ready,
   input  wire rsp_type            rsp_data,
   input  wire logic               csr_wr_en,
   input  wire logic [LIMIT_W-1:0] csr_wr_data,
   output int                      fail_count,
   output int                      pending_corners
);
   localparam int FB = FRAC_BITS_DEF;

   logic [LIMIT_W-1:0] limit_shadow;
   rsp_type corner_queue[$];

   // exact quotient (num * 2^FB) / den, truncated toward zero, saturated
   function automatic logic [31:0] fixed_div(input logic signed [127:0] num,
                                             input logic signed [127:0] den);
      logic signed [191:0] n, d, q;
      n = num;
      d = den;
      n = n <<< FB;
      q = n / d;
      if (q > 192'sd2147483647) return 32'h7FFFFFFF;
      if (q < -192'sd2147483648) return 32'h80000000;
      return q[31:0];
   endfunction

   function automatic rsp_type solve_corners(input req_type t,
                                             input logic [LIMIT_W-1:0] lim);
      logic signed [127:0] m[3][3];
      logic signed [127:0] rhs[3];
      logic signed [127:0] cof[3][3];
      logic signed [127:0] det, mag, num;
      logic signed [127:0] b[3];
      logic [31:0] coord[9];
      rsp_type r;
      m[0][0] = t.plane_nx; m[0][1] = t.plane_ny; m[0][2] = t.plane_nz;
      m[1][0] = t.s_x;      m[1][1] = t.s_y;      m[1][2] = t.s_z;
      m[2][0] = t.t_x;      m[2][1] = t.t_y;      m[2][2] = t.t_z;
      rhs[0] = t.plane_dist; rhs[1] = t.s_offset; rhs[2] = t.t_offset;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            cof[i][j] = m[(i+1)%3][(j+1)%3] * m[(i+2)%3][(j+2)%3]
                      - m[(i+1)%3][(j+2)%3] * m[(i+2)%3][(j+1)%3];
      det = 0;
      for (int j = 0; j < 3; j++) det += m[0][j] * cof[0][j];
      mag = (det < 0) ? -det : det;
      r = '0;
      if (mag == 0 || mag < $signed({80'd0, lim})) begin
         r.singular = 1'b1;
         return r;
      end
      for (int k = 0; k < 3; k++) begin
         b[0] = rhs[0];
         b[1] = rhs[1] + ((k == 1) ? (128'sd1 <<< FB) : 0);
         b[2] = rhs[2] + ((k == 2) ? (128'sd1 <<< FB) : 0);
         for (int j = 0; j < 3; j++) begin
            num = 0;
            for (int i = 0; i < 3; i++) num += b[i] * cof[i][j];
            coord[k*3+j] = fixed_div(num, det);
         end
      end
      r.a_x = coord[0]; r.a_y = coord[1]; r.a_z = coord[2];
      r.b_x = coord[3]; r.b_y = coord[4]; r.b_z = coord[5];
      r.c_x = coord[6]; r.c_y = coord[7]; r.c_z = coord[8];
      return r;
   endfunction

   assign pending_corners = corner_queue.size();

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         limit_shadow <= LIMIT_RESET;
         fail_count   <= 0;
      end else begin
         if (csr_wr_en) limit_shadow <= csr_wr_data;
         if (req_valid && req_ready)
            corner_queue.push_back(solve_corners(req_data, limit_shadow));
         if (rsp_valid && rsp_ready) begin
            if (corner_queue.size() == 0) begin
               $display("%0t: unexpected transfer, actual %h", $time, rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = corner_queue.pop_front();
               if (rsp_data !== want) begin
                  $display("%0t: corner mismatch, expected %h actual %h",
                           $time, want, rsp_data);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

/* dv/tb_triangle_from_planes_cramer.sv */
// Testbench top for the triangle corner solver: stimulus, pacing and verdict
`timescale 1ns / 100ps
module tb_triangle_from_planes_cramer
   import tfpc_pkg::*;
;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_wr_en = 1'b0;
   logic [LIMIT_W-1:0] csr_wr_data = '0;
   int fail_count, pending_corners, idle_cycles;
   bit stall_mode = 1'b0;

   always #4 clock = ~clock;

   triangle_from_planes_cramer u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   tfpc_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .fail_count(fail_count), .pending_corners(pending_corners)
   );

   // receiver stall pattern: phases of light stalls and of heavy stalls
   always @(negedge clock) begin
      if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;
      rsp_ready <= stall_mode ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 9) != 0);
   end

   // watchdog on cycles with no transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else if (idle_cycles == 20000) begin
         $display("RESULT: ERROR");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   int burst_left = 0;

   task automatic send_triangle(input req_type t);
      if (burst_left == 0) begin
         repeat ($urandom_range(0, 6)) @(negedge clock);
         burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      req_data  <= t;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      if (burst_left == 0) req_valid <= 1'b0;
   endtask

   // called at a falling edge, right after the last transfer
   task automatic write_limit(input logic [LIMIT_W-1:0] v);
      req_valid <= 1'b0;
      while (pending_corners != 0) @(negedge clock);
      repeat (PIPE_STAGES + 4) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      burst_left = 0;
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return 32'($signed($urandom_range(0, 8)) - 4) <<< 16;
         2: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
         3: return 32'($signed($urandom_range(0, 2000)) - 1000);
         default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      endcase
   endfunction

   function automatic req_type rand_triangle();
      req_type t;
      t = {rand_coord(), rand_coord(), rand_coord(), rand_coord(),
           rand_coord(), rand_coord(), rand_coord(), rand_coord(),
           rand_coord(), rand_coord(), rand_coord(), rand_coord()};
      // make some rows dependent to hit singular matrices
      if ($urandom_range(0, 9) == 0) begin
         t.t_x = t.s_x; t.t_y = t.s_y; t.t_z = t.s_z;
      end
      return t;
   endfunction

   localparam logic [31:0] ONE = 32'h0001_0000;
   localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
   localparam logic [31:0] MINV = 32'h8000_0000;

   initial begin
      logic [LIMIT_W-1:0] limits[4];
      limits = '{48'd0, 48'hFFFF_FFFF_FFFF, 48'd1, 48'd281474977};
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: identity, scaled, saturating, singular cases
      send_triangle({ONE, 32'd0, 32'd0, 32'h0003_0000, 32'd0, ONE, 32'd0, 32'hFFFE_0000,
                     32'd0, 32'd0, ONE, 32'h0000_8000});
      send_triangle('0);
      send_triangle({MAXV, 32'd0, 32'd0, MAXV, 32'd0, MAXV, 32'd0, MINV,
                     32'd0, 32'd0, MAXV, MAXV});
      send_triangle({MINV, 32'd0, 32'd0, MAXV, 32'd0, MINV, 32'd0, MINV,
                     32'd0, 32'd0, MINV, MAXV});
      send_triangle({32'd1, 32'd0, 32'd0, MAXV, 32'd0, 32'd1, 32'd0, MINV,
                     32'd0, 32'd0, 32'd1, MAXV});
      send_triangle({32'h100, 32'd0, 32'd0, 32'd5, 32'd0, 32'h100, 32'd0, 32'd5,
                     32'd0, 32'd0, 32'h100, 32'd5});
      send_triangle({32'h101, 32'd0, 32'd0, 32'd5, 32'd0, 32'h100, 32'd0, 32'd5,
                     32'd0, 32'd0, 32'h100, 32'd5});
      send_triangle({ONE, ONE, ONE, MINV, ONE, ONE, ONE, MAXV, ONE, ONE, 32'h0002_0000,
                     MINV});
      send_triangle({12{32'hFFFF_FFFF}});
      send_triangle({12{32'h5555_5555}});
      send_triangle({12{32'hAAAA_AAAA}});
      for (int i = 0; i < 8; i++) send_triangle(rand_triangle());

      for (int p = 0; p < 5; p++) begin
         write_limit(p < 4 ? limits[p] : {$urandom(), 16'($urandom())} >> $urandom_range(0, 47));
         for (int i = 0; i < 220; i++) send_triangle(rand_triangle());
      end

      req_valid <= 1'b0;
      while (pending_corners != 0) @(negedge clock);
      repeat (PIPE_STAGES + 10) @(negedge clock);
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end
endmodule
